// ===== hw/rtl/slxfr_pkg.sv =====
// Shared constants and types for the sync/length/XOR frame receiver.
package slxfr_pkg;

  localparam logic [7:0]  SyncA           = 8'hEB;
  localparam logic [7:0]  SyncB           = 8'h90;
  localparam logic [15:0] MaxPayloadReset = 16'd293;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_CSUM = 2'd2,
    KIND_LEN  = 2'd3
  } kind_e;

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_S2   = 8'b0000_0010,
    PH_S3   = 8'b0000_0100,
    PH_S4   = 8'b0000_1000,
    PH_LHI  = 8'b0001_0000,
    PH_LLO  = 8'b0010_0000,
    PH_DATA = 8'b0100_0000,
    PH_CHK  = 8'b1000_0000
  } phase_e;

endpackage

// ===== hw/rtl/sync_length_xor_frame_receiver.sv =====
// Sync-word / length / XOR-checksum frame receiver, top level.
//
// Input channel (in_valid_i/in_ready_o, rx_byte_i): one received serial
// byte per word. The block hunts for EB 90 EB 90, reads a big-endian
// 16-bit payload length, then forwards each payload byte with its index
// and checks the trailing XOR checksum byte.
// Output channel (out_valid_o/out_ready_i): at most one result word per
// input word: payload byte (index), frame good / checksum error (length,
// received checksum, last set), or length error (length, last set).
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): max_payload, always
// ready; the user must write it only while the block is idle (not enforced).
// Path: an accepted byte is registered in the input register, decoded from
// there, and its result is captured in the output register.
// Throughput: one word per cycle unless stalled; frame state is the only loop.
// Reset: hunting, pipeline empty, max_payload = 293.
// Stall: while a result waits on out_ready_i the input register holds;
// if it is empty one more byte is taken into it, then in_ready_o drops.
module sync_length_xor_frame_receiver
  import slxfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] out_index_o,
  output logic        out_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // configuration register
  logic [15:0] max_payload_q;

  // input register stage
  logic        in_valid_q;
  logic [7:0]  rx_q;

  // frame state
  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  xor_q, xor_d;

  // result register
  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [15:0] oindex_q, oindex_d;
  logic        olast_q, olast_d;
  logic        has_res;

  logic        advance;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  phase_e      restart;

  // The decode stage moves whenever the result register is free or drains.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign len_full  = {len_q[15:8], rx_q};
  assign count_inc = count_q + 16'd1;
  // A mismatching EB starts a new sync attempt.
  assign restart   = (rx_q == SyncA) ? PH_S2 : PH_HUNT;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    count_d  = count_q;
    xor_d    = xor_q;
    has_res  = 1'b0;
    kind_d   = KIND_DATA;
    obyte_d  = rx_q;
    oindex_d = count_q;
    olast_d  = 1'b0;
    unique case (phase_q)
      PH_HUNT: phase_d = restart;
      PH_S2:   phase_d = (rx_q == SyncB) ? PH_S3 : restart;
      PH_S3:   phase_d = (rx_q == SyncA) ? PH_S4 : restart;
      PH_S4:   phase_d = (rx_q == SyncB) ? PH_LHI : restart;
      PH_LHI: begin
        len_d   = {rx_q, 8'h00};
        phase_d = PH_LLO;
      end
      PH_LLO: begin
        len_d   = len_full;
        count_d = '0;
        xor_d   = '0;
        if (len_full > max_payload_q) begin
          has_res  = 1'b1;
          kind_d   = KIND_LEN;
          obyte_d  = '0;
          oindex_d = len_full;
          olast_d  = 1'b1;
          phase_d  = PH_HUNT;
        end else begin
          phase_d = (len_full == '0) ? PH_CHK : PH_DATA;
        end
      end
      PH_DATA: begin
        has_res = 1'b1;
        xor_d   = xor_q ^ rx_q;
        count_d = count_inc;
        if (count_inc == len_q) begin
          phase_d = PH_CHK;
        end
      end
      PH_CHK: begin
        has_res  = 1'b1;
        kind_d   = (rx_q == xor_q) ? KIND_GOOD : KIND_CSUM;
        oindex_d = len_q;
        olast_d  = 1'b1;
        phase_d  = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q       <= PH_HUNT;
      len_q         <= '0;
      count_q       <= '0;
      xor_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_payload_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && has_res;
      end
      if (in_valid_q && advance) begin
        phase_q <= phase_d;
        len_q   <= len_d;
        count_q <= count_d;
        xor_q   <= xor_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rx_q <= rx_byte_i;
    end
    if (advance && in_valid_q && has_res) begin
      kind_q   <= kind_d;
      obyte_q  <= obyte_d;
      oindex_q <= oindex_d;
      olast_q  <= olast_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = obyte_q;
  assign out_index_o = oindex_q;
  assign out_last_o  = olast_q;

endmodule

// ===== hw/rtl/slxfr_checker.sv =====
// Port-level assertions for the frame receiver, bound to the top level.
module slxfr_checker
  import slxfr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_o,
  input logic [7:0]  out_byte_o,
  input logic        out_last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // payload words never close a frame
  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_DATA |-> !out_last_o)
    else $error("payload word flagged last");

  // every end or abort result closes the frame
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != KIND_DATA |-> out_last_o)
    else $error("end result without last");

  // a length error carries no byte
  a_len_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_LEN |-> out_byte_o == 8'h00)
    else $error("length error with nonzero byte");

endmodule

bind sync_length_xor_frame_receiver slxfr_checker u_slxfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_kind_o  (out_kind_o),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the sync/length/XOR frame receiver.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slxfr_pkg::*;

  // A byte passes the input register and its result word the result register;
  // this sets the drain wait before a register write and at the end of the run.
  localparam int DRAIN_CYCLES = 6;
  // Bytes of random traffic per max_payload setting.
  localparam int BYTES_PER_SETTING = 230;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic        last;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;  // expectation spelled out in the row
    frame_result_t want;
  } script_row_t;

  localparam frame_result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] out_index;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // Deframer state as predicted by the testbench.
  phase_e      rx_phase;
  logic [15:0] frame_len;
  logic [15:0] bytes_seen;
  logic [7:0]  frame_xor;
  logic [15:0] max_len;

  frame_result_t pending_results[$];
  int            mismatches = 0;
  int            bytes_sent = 0;
  // Input idle bursts and output stalls start at odds of 1 in idle_odds; 0 turns them off.
  int            idle_odds = 0;

  sync_length_xor_frame_receiver DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_kind_o  (out_kind),
    .out_byte_o  (out_byte),
    .out_index_o (out_index),
    .out_last_o  (out_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A broken sync pattern sends the hunt back to the start, except that a
  // stray EB is already the first byte of a new pattern.
  function automatic phase_e resync(input logic [7:0] b);
    return (b == SyncA) ? PH_S2 : PH_HUNT;
  endfunction

  // Advances the predicted deframer by one byte; returns 1 when the byte
  // produces a result word, which is then left in r.
  function automatic logic predict_byte(input logic [7:0] b, output frame_result_t r);
    logic hit;
    r = NO_RESULT;
    hit = 1'b0;
    case (rx_phase)
      PH_HUNT: rx_phase = resync(b);
      PH_S2:   rx_phase = (b == SyncB) ? PH_S3 : resync(b);
      PH_S3:   rx_phase = (b == SyncA) ? PH_S4 : resync(b);
      PH_S4:   rx_phase = (b == SyncB) ? PH_LHI : resync(b);
      PH_LHI: begin
        frame_len = {b, 8'h00};
        rx_phase = PH_LLO;
      end
      PH_LLO: begin
        frame_len = {frame_len[15:8], b};
        bytes_seen = '0;
        frame_xor = '0;
        if (frame_len > max_len) begin
          // Oversized frame: abort with the length that was received.
          r = '{KIND_LEN, 8'h00, frame_len, 1'b1};
          hit = 1'b1;
          rx_phase = PH_HUNT;
        end else begin
          // An empty frame goes straight to its checksum byte.
          rx_phase = (frame_len == 16'd0) ? PH_CHK : PH_DATA;
        end
      end
      PH_DATA: begin
        r = '{KIND_DATA, b, bytes_seen, 1'b0};
        hit = 1'b1;
        frame_xor = frame_xor ^ b;
        bytes_seen = bytes_seen + 16'd1;
        if (bytes_seen == frame_len) rx_phase = PH_CHK;
      end
      default: begin
        r = '{(b == frame_xor) ? KIND_GOOD : KIND_CSUM, b, frame_len, 1'b1};
        hit = 1'b1;
        rx_phase = PH_HUNT;
      end
    endcase
    return hit;
  endfunction

  // Offers one byte and waits for the handshake. The expectation is taken
  // from the row when typed is set, otherwise from the predictor, which is
  // stepped in both cases. An idle burst may follow.
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_result_t want);
    frame_result_t got;
    logic          hit;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    hit = predict_byte(b, got);
    if (typed) pending_results.push_back(want);
    else if (hit) pending_results.push_back(got);
    bytes_sent++;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Writes max_payload once the block has gone quiet.
  task automatic set_max_payload(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A byte with no result may still sit in the pipeline.
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len = value;
  endtask

  // Mostly well-formed frames with random content; the rest is line noise,
  // broken sync patterns and oversized lengths.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned spare;
    int unsigned bad_at;
    logic [7:0]  b;
    logic [7:0]  sum;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Noise, rich in sync bytes so that partial patterns show up.
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 2))
          0:       b = SyncA;
          1:       b = SyncB;
          default: b = 8'($urandom);
        endcase
        send_byte(b, 1'b0, NO_RESULT);
      end
    end else begin
      bad_at = (pick < 22) ? $urandom_range(0, 3) : 4;
      for (int k = 0; k < 4; k++) begin
        b = k[0] ? SyncB : SyncA;
        if (k == bad_at) b = 8'($urandom);
        send_byte(b, 1'b0, NO_RESULT);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15 && max_len != 16'hFFFF) begin
        // Just over the limit, or anywhere above it.
        spare = 65534 - max_len;
        len = max_len + 1 + ((pick < 5) ? $urandom_range(0, spare)
                                        : $urandom_range(0, (spare < 3) ? spare : 3));
      end else if (pick < 25) begin
        len = (max_len < 300) ? max_len : $urandom_range(0, 300);
      end else if (pick < 35) begin
        len = 0;
      end else begin
        len = $urandom_range(0, (max_len < 24) ? max_len : 24);
      end
      send_byte(8'(len >> 8), 1'b0, NO_RESULT);
      send_byte(8'(len), 1'b0, NO_RESULT);
      if (len <= max_len) begin
        sum = '0;
        repeat (len) begin
          b = 8'($urandom);
          sum = sum ^ b;
          send_byte(b, 1'b0, NO_RESULT);
        end
        // Mostly a correct checksum, else one with a single flipped bit.
        if ($urandom_range(0, 99) < 70) send_byte(sum, 1'b0, NO_RESULT);
        else send_byte(sum ^ (8'h01 << $urandom_range(0, 7)), 1'b0, NO_RESULT);
      end
    end
  endtask

  // Directed opening, run at the reset value of max_payload (293).
  script_row_t script [25] = '{
    // empty frame; its checksum is the XOR of nothing
    '{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
    '{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{KIND_GOOD, 8'h00, 16'd0, 1'b1}},
    // an EB where the second 90 belongs restarts the hunt on itself,
    // then the largest possible length is refused
    '{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
    '{8'hEB, 1'b0, NO_RESULT}, '{8'hEB, 1'b0, NO_RESULT},
    '{8'h90, 1'b0, NO_RESULT}, '{8'hEB, 1'b0, NO_RESULT},
    '{8'h90, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{KIND_LEN, 8'h00, 16'hFFFF, 1'b1}},
    // two payload bytes at the extremes, then a wrong checksum
    '{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
    '{8'hEB, 1'b0, NO_RESULT}, '{8'h90, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h02, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, '{KIND_DATA, 8'hFF, 16'd0, 1'b0}},
    '{8'h00, 1'b1, '{KIND_DATA, 8'h00, 16'd1, 1'b0}},
    '{8'h00, 1'b1, '{KIND_CSUM, 8'h00, 16'd2, 1'b1}}
  };

  // Result checker: every word taken from the output is matched against
  // the oldest pending expectation, field by field.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("unexpected result word kind %0d byte %02h index %0d",
               out_kind, out_byte, out_index);
      end else begin
        want = pending_results.pop_front();
        if (out_kind != want.kind || out_byte != want.data ||
            out_index != want.index || out_last != want.last) begin
          mismatches++;
          if (out_kind != want.kind)
            $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          if (out_byte != want.data)
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          if (out_index != want.index)
            $error("out_index: expected %0d, got %0d", want.index, out_index);
          if (out_last != want.last)
            $error("out_last: expected %0d, got %0d", want.last, out_last);
        end
      end
    end
  end

  // Output back-pressure: random stalls while idling is on.
  initial begin
    out_ready = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed script, then random traffic under a
  // series of max_payload settings, ending at the reset value with no idling.
  initial begin
    logic [15:0] limits [7];
    int          phase_end;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    cfg_valid = 1'b0;
    cfg_data  = 16'h0000;
    rx_phase   = PH_HUNT;
    frame_len  = '0;
    bytes_seen = '0;
    frame_xor  = '0;
    max_len    = MaxPayloadReset;
    limits = '{16'd0, 16'hFFFF, 16'd1, 16'd12, 16'($urandom), 16'd255, MaxPayloadReset};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_odds = 3;
    foreach (script[r]) send_byte(script[r].rx, script[r].typed, script[r].want);

    for (int p = 0; p < 7; p++) begin
      set_max_payload(limits[p]);
      // Pick at random between stretches with and without idling; the last
      // setting runs flat out.
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 3;
        default: idle_odds = 6;
      endcase
      if (p == 6) idle_odds = 0;
      phase_end = bytes_sent + BYTES_PER_SETTING;
      while (bytes_sent < phase_end) send_random_frame();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
